// ----- design/rwcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwcmp_pkg
// shared types and constants of the rook walk counter
// ----------------------------------------------------------------------------
package rwcmp_pkg;

   localparam int MAX_STEP_BITS = 60;
   localparam int STEP_W        = 60;
   localparam int COORD_W       = 30;
   localparam int RES_W         = 30;
   localparam int BIT_IDX_W     = $clog2(MAX_STEP_BITS + 1);
   localparam logic [29:0] PRIME_MOD = 30'd998244353;
   // floor(2^60 / p) for barrett reduction of a 60-bit product
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / {34'b0, PRIME_MOD});

   localparam logic [0:0] REG_GRID_ROWS = 1'd0;
   localparam logic [0:0] REG_GRID_COLS = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_MUL,
      ST_STORE,
      ST_NEXT,
      ST_DONE
   } state_type;

   // one multiply-accumulate request to the modular unit
   typedef struct packed {
      logic        start;
      logic        clear;
      logic [29:0] a;
      logic [29:0] b;
   } mac_req_type;

endpackage

// ----- design/rwcmp_if.sv -----
// ----------------------------------------------------------------------------
// rwcmp_req_if / rwcmp_rsp_if / rwcmp_csr_if
// valid/ready channels of the rook walk counter
// ----------------------------------------------------------------------------
interface rwcmp_req_if;
   import rwcmp_pkg::*;
   logic               valid;
   logic               ready;
   logic [STEP_W-1:0]  step_count;
   logic [COORD_W-1:0] start_row;
   logic [COORD_W-1:0] start_col;
   logic [COORD_W-1:0] end_row;
   logic [COORD_W-1:0] end_col;
   modport source (output valid, step_count, start_row, start_col, end_row, end_col,
                   input ready);
   modport sink   (input valid, step_count, start_row, start_col, end_row, end_col,
                   output ready);
endinterface

interface rwcmp_rsp_if;
   import rwcmp_pkg::*;
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] walk_count;
   modport source (output valid, walk_count, input ready);
   modport sink   (input valid, walk_count, output ready);
endinterface

interface rwcmp_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/rook_walk_count_matrix_power_top.sv -----
// ----------------------------------------------------------------------------
// rook_walk_count_matrix_power_top
// rook walk counter by 4x4 matrix power modulo 998244353
// ----------------------------------------------------------------------------
// csr channel writes grid_rows (index 0) and grid_cols (index 1); always ready
// req channel carries one query transaction; ready only while idle
// rsp channel returns walk_count; the block waits until it is taken
// each exponent bit runs two 4x4 products of 64 multiply-accumulates each
// on the single modular mac unit, with a store state after each entry
// rsp valid rises only after all 60 exponent bits have run, for any step
// count; the next request is not taken before the previous result is
// reset is synchronous, active high; grid size returns to 2 x 2 and any
// query in flight is dropped
// a stalled receiver holds the result; no new request is taken meanwhile
// ----------------------------------------------------------------------------
module rook_walk_count_matrix_power_top
   import rwcmp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rwcmp_csr_if.sink  csr,
   rwcmp_req_if.sink  req,
   rwcmp_rsp_if.source rsp
);
   logic [29:0] rows_ff, cols_ff;
   logic [29:0] base_ff [16];
   logic [29:0] accm_ff [16];
   logic [29:0] tmp_ff  [16];
   logic [STEP_W-1:0] step_ff;
   logic [1:0]  sel_ff;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic        phase_ff, phase_in;   // 0 acc*base, 1 base*base
   logic [5:0]  idx_ff, idx_in;       // i,j,t
   logic        busy_ff, busy_in;
   logic [29:0] res_ff;
   state_type   state_ff, state_in;
   mac_req_type mreq;
   logic        mdone;
   logic [29:0] macc;
   logic [1:0]  ii, jj, tt;
   logic [29:0] lhs;

   function automatic logic [29:0] msub(input logic [30:0] x, input logic [30:0] s);
      logic [30:0] v;
      v = x;
      if (v >= {1'b0, PRIME_MOD}) v = v - {1'b0, PRIME_MOD};
      if (v >= {1'b0, PRIME_MOD}) v = v - {1'b0, PRIME_MOD};
      v = (v >= s) ? v - s : v + {1'b0, PRIME_MOD} - s;
      return v[29:0];
   endfunction

   assign ii = idx_ff[5:4];
   assign jj = idx_ff[3:2];
   assign tt = idx_ff[1:0];

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_DONE);
   assign rsp.walk_count = res_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_BUILD;
         ST_BUILD: state_in = ST_MUL;
         ST_MUL:   if (mdone && tt == 2'd3) state_in = ST_STORE;
         ST_STORE: state_in = (idx_ff == 6'd63) ? ST_NEXT : ST_MUL;
         ST_NEXT:  state_in = (phase_ff && bit_ff == BIT_IDX_W'(MAX_STEP_BITS - 1)) ?
                              ST_DONE : ST_MUL;
         ST_DONE:  if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign lhs = phase_ff ? base_ff[{ii, tt}] : accm_ff[{ii, tt}];

   always_comb begin
      mreq.start = 1'b0;
      mreq.clear = (tt == 2'd0);
      mreq.a     = lhs;
      mreq.b     = base_ff[{tt, jj}];
      idx_in     = idx_ff;
      bit_in     = bit_ff;
      phase_in   = phase_ff;
      busy_in    = busy_ff;
      case (state_ff)
         ST_BUILD: begin
            idx_in = '0; bit_in = '0; phase_in = 1'b0; busy_in = 1'b0;
         end
         ST_MUL: begin
            mreq.start = !busy_ff;
            busy_in    = 1'b1;
            if (mdone) begin
               busy_in = 1'b0;
               if (tt != 2'd3) idx_in = idx_ff + 6'd1;
            end
         end
         ST_STORE: idx_in = idx_ff + 6'd1;
         ST_NEXT: begin
            phase_in = !phase_ff;
            if (phase_ff) bit_in = bit_ff + BIT_IDX_W'(1);
         end
         default: ;
      endcase
   end

   rwcmp_mac u_mac (.clock(clock), .reset(reset), .req(mreq), .done(mdone), .acc(macc));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= 30'd2;
         cols_ff  <= 30'd2;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_GRID_ROWS: rows_ff <= csr.data[29:0];
               REG_GRID_COLS: cols_ff <= csr.data[29:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      phase_ff <= phase_in;
      if (state_ff == ST_IDLE && req.valid) begin
         step_ff <= req.step_count;
         sel_ff  <= {req.start_row == req.end_row, req.start_col == req.end_col};
      end
      if (state_ff == ST_BUILD) begin
         for (int k = 0; k < 16; k++) begin
            base_ff[k] <= '0;
            accm_ff[k] <= (k % 5 == 0) ? 30'd1 : 30'd0;
         end
         base_ff[0]  <= msub({1'b0, rows_ff} + {1'b0, cols_ff}, 31'd4);
         base_ff[1]  <= msub({1'b0, cols_ff}, 31'd1);
         base_ff[2]  <= msub({1'b0, rows_ff}, 31'd1);
         base_ff[4]  <= 30'd1;
         base_ff[5]  <= msub({1'b0, rows_ff}, 31'd2);
         base_ff[7]  <= msub({1'b0, rows_ff}, 31'd1);
         base_ff[8]  <= 30'd1;
         base_ff[10] <= msub({1'b0, cols_ff}, 31'd2);
         base_ff[11] <= msub({1'b0, cols_ff}, 31'd1);
         base_ff[13] <= 30'd1;
         base_ff[14] <= 30'd1;
      end
      if (state_ff == ST_STORE) tmp_ff[{ii, jj}] <= macc;
      if (state_ff == ST_NEXT) begin
         for (int k = 0; k < 16; k++) begin
            if (phase_ff) base_ff[k] <= tmp_ff[k];
            else if (step_ff[bit_ff]) accm_ff[k] <= tmp_ff[k];
         end
         if (phase_ff && bit_ff == BIT_IDX_W'(MAX_STEP_BITS - 1))
            res_ff <= accm_ff[{2'd3, sel_ff}];
      end
   end

   a_busy_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(res_ff)) else $error("result dropped");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> res_ff < PRIME_MOD) else $error("result out of range");
endmodule

// ----- design/rwcmp_mac.sv -----
// ----------------------------------------------------------------------------
// rwcmp_mac
// modular mac: acc = (acc + a*b) mod p, or a*b mod p on clear; done after start
// ----------------------------------------------------------------------------
module rwcmp_mac
   import rwcmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mac_req_type req,
   output logic        done,
   output logic [29:0] acc
);
   logic [59:0] prod_ff, prod_in;
   logic [30:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [29:0] red_ff, red_in;
   logic [29:0] acc_ff, acc_in;
   logic [4:0]  vld_ff, vld_in;
   logic        clr_ff, clr_in;
   logic [61:0] qprod;
   logic [31:0] rem_one;
   logic [30:0] sum;

   // barrett reduction of the product through quot_ff, rem_ff and red_ff
   always_comb begin
      qprod   = {31'b0, prod_ff[59:29]} * {31'b0, BARRETT_MU};
      rem_one = (rem_ff >= {2'b0, PRIME_MOD}) ? rem_ff - {2'b0, PRIME_MOD} : rem_ff;
      prod_in = prod_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      red_in  = red_ff;
      vld_in  = vld_ff;
      clr_in  = clr_ff;
      acc_in  = acc_ff;
      sum     = {1'b0, acc_ff} + {1'b0, red_ff};
      if (req.start) begin
         prod_in = {30'b0, req.a} * {30'b0, req.b};
         vld_in  = 5'b00001;
         clr_in  = req.clear;
      end else if (vld_ff[0]) begin
         quot_in = qprod[61:31];
         vld_in  = 5'b00010;
      end else if (vld_ff[1]) begin
         rem_in  = prod_ff[31:0] - ({1'b0, quot_ff} * {2'b0, PRIME_MOD});
         vld_in  = 5'b00100;
      end else if (vld_ff[2]) begin
         red_in  = (rem_one >= {2'b0, PRIME_MOD}) ? 30'(rem_one - {2'b0, PRIME_MOD}) :
                                                    rem_one[29:0];
         vld_in  = 5'b01000;
      end else if (vld_ff[3]) begin
         if (clr_ff) sum = {1'b0, red_ff};
         acc_in = (sum >= {1'b0, PRIME_MOD}) ? 30'(sum - {1'b0, PRIME_MOD}) : sum[29:0];
         vld_in = 5'b10000;
      end else begin
         vld_in = 5'b00000;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      red_ff  <= red_in;
      acc_ff  <= acc_in;
      clr_ff  <= clr_in;
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   assign done = vld_ff[4];
   assign acc  = acc_ff;

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(vld_ff))
      else $error("mac phase not onehot");
   a_range: assert property (@(posedge clock) disable iff (reset) done |-> acc_ff < PRIME_MOD)
      else $error("mac result out of range");
   a_done: assert property (@(posedge clock) disable iff (reset) vld_ff[3] |=> done)
      else $error("mac done missing");
endmodule
